>>> design/cfb_pkg.sv
// shared types, constants and the crc-8 byte update for the block framer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cfb_pkg;

  localparam int GROUP_DATA_BYTES = 7;
  localparam int POS_W = $clog2(GROUP_DATA_BYTES + 1);
  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_PAD     = 2'd1,
    KIND_CHECK   = 2'd2
  } byte_kind_t;

  typedef struct packed {
    logic [7:0] value;
    byte_kind_t kind;
    logic       failed;
    logic       eor;
  } result_t;

  // reflected crc-8, lsb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    for (int b = 0; b < 8; b++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/cfb_engine.sv
// group position, crc accumulator, mode register and the pad/check sequencer
// depends on cfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module cfb_engine (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic            cfg_wr_data,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_last_byte,
  input  wire logic            load_en,
  output logic                 res_valid,
  output cfb_pkg::result_t     res
);
  import cfb_pkg::*;

  localparam pos_t POS_FULL = POS_W'(GROUP_DATA_BYTES);

  logic       mode_r;
  logic       tail_r, tail_nxt;
  pos_t       pos_r, pos_nxt;
  logic [7:0] crc_r, crc_nxt;

  logic       accept;
  logic [7:0] crc_data;
  logic [7:0] crc_zero;
  pos_t       pos_inc;

  assign in_stall  = tail_r | ~load_en;
  assign accept    = in_valid & ~in_stall;
  assign res_valid = load_en & (tail_r | in_valid);
  assign crc_data  = crc8_update(crc_r, in_data_byte);
  assign crc_zero  = crc8_update(crc_r, 8'h00);
  assign pos_inc   = (pos_r < POS_FULL) ? pos_r + pos_t'(1) : pos_r;

  always_comb begin
    tail_nxt   = tail_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    res.value  = in_data_byte;
    res.kind   = KIND_PAYLOAD;
    res.failed = 1'b0;
    res.eor    = 1'b1;
    if (tail_r) begin
      if (pos_r < POS_FULL) begin
        res.value = 8'h00;
        res.kind  = KIND_PAD;
        res.eor   = 1'b0;
        if (load_en) begin
          crc_nxt = crc_zero;
          pos_nxt = pos_r + pos_t'(1);
        end
      end else begin
        res.value = crc_r;
        res.kind  = KIND_CHECK;
        if (load_en) begin
          crc_nxt  = 8'h00;
          pos_nxt  = '0;
          tail_nxt = 1'b0;
        end
      end
    end else if (mode_r == MODE_ENCODE) begin
      res.eor = ~(in_last_byte | (pos_inc >= POS_FULL));
      if (accept) begin
        crc_nxt  = crc_data;
        pos_nxt  = pos_inc;
        tail_nxt = in_last_byte | (pos_inc >= POS_FULL);
      end
    end else begin
      if (pos_r >= POS_FULL) begin
        res.kind   = KIND_CHECK;
        res.failed = in_data_byte != crc_r;
        if (accept) begin
          crc_nxt = 8'h00;
          pos_nxt = '0;
        end
      end else if (accept) begin
        crc_nxt = crc_data;
        pos_nxt = pos_r + pos_t'(1);
      end
      if (accept && in_last_byte) begin
        crc_nxt = 8'h00;
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
      tail_r <= 1'b0;
      pos_r  <= '0;
      crc_r  <= 8'h00;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      tail_r <= tail_nxt;
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/cfb_out_reg.sv
// result register between the sequencer and the output channel
// depends on cfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module cfb_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_valid,
  input  wire cfb_pkg::result_t  res,
  output logic                   load_en,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cfb_pkg::result_t       out_res
);
  import cfb_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign load_en   = ~valid_r | ~out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_en) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && res_valid) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

>>> design/crc8_protected_block_framer.sv
// crc-8 protected block framer, top level
// depends on cfb_pkg, cfb_engine and cfb_out_reg
`timescale 1ns / 1ps
`default_nettype none

// Frames a byte stream into groups of seven payload bytes, each closed by a
// reflected crc-8 check byte (polynomial 0x8C, initial value zero). One input
// request is taken per clock while in_stall is low, and its first result is
// loaded into the output register on the clock edge that takes it. In encode
// mode a group end adds the check byte, and a final byte adds zero pads up to
// the group end and then the check byte, from the pad/check sequencer, which
// holds in_stall high while it runs. Decode mode gives a result per request.
// mode must only be written while the block is idle.
module crc8_protected_block_framer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_out_byte,
  output logic [1:0]      out_byte_kind,
  output logic            out_check_failed,
  output logic            out_end_of_run
);
  import cfb_pkg::*;

  logic    load_en;
  logic    res_valid;
  result_t res;
  result_t out_res;

  cfb_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .load_en      (load_en),
    .res_valid    (res_valid),
    .res          (res)
  );

  cfb_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .load_en   (load_en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_out_byte     = out_res.value;
  assign out_byte_kind    = out_res.kind;
  assign out_check_failed = out_res.failed;
  assign out_end_of_run   = out_res.eor;

endmodule

`default_nettype wire
